// File: sv/wpc_pkg.sv
// Shared types and constants for the weighted Pearson correlation core.
// Used by wpc_controller, wpc_datapath and the top level; no dependencies.
package wpc_pkg;

   localparam int WT_W   = 29;   // weight total
   localparam int SX_W   = 46;   // weighted x / y sums
   localparam int SXX_W  = 59;   // weighted xx / yy sums
   localparam int SXY_W  = 60;   // weighted xy sum
   localparam int VAR_W  = 96;   // variance terms and numerator, two's complement
   localparam int ACC_W  = 216;  // shift-add accumulator
   localparam int LHS_W  = ACC_W - 32;
   localparam int ODD_W  = 17;
   localparam int C2_W   = 2 * ODD_W;
   localparam int Q_W    = 16;
   localparam int BIT_W  = 4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_WEIGHT = 2'd1;
   localparam logic [1:0] STATUS_ZERO_VAR  = 2'd2;

   localparam logic [Q_W-1:0] Q_LIMIT  = 16'h8000;
   localparam logic [Q_W-1:0] CORR_MAX = 16'h7FFF;

   typedef enum logic [3:0] {
      JOB_W_SXX,
      JOB_SX_SX,
      JOB_W_SYY,
      JOB_SY_SY,
      JOB_W_SXY,
      JOB_SX_SY,
      JOB_VX_VY,
      JOB_NUM_NUM,
      JOB_ODD_SQ,
      JOB_C2_P
   } job_type;

   typedef struct packed {
      logic       mul_start;
      logic       store;
      job_type    job;
      logic       search_init;
      logic       emit;
      logic [1:0] status;
      logic       clear_sums;
   } wpc_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic weight_zero;
      logic var_bad;
      logic last_bit;
   } wpc_stat_type;

endpackage

// File: sv/wpc_controller.sv
// Sequencer for the finishing math: drains the row pipeline, runs the
// multiply jobs in order and drives the bit search. Depends on wpc_pkg.
module wpc_controller
   import wpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         last_row,
   input  wpc_stat_type stat,
   output wpc_cmd_type  cmd,
   output logic         busy
);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DRAIN1    = 8'b0000_0010,
      S_DRAIN2    = 8'b0000_0100,
      S_CHECK_W   = 8'b0000_1000,
      S_ISSUE     = 8'b0001_0000,
      S_RUN       = 8'b0010_0000,
      S_CHECK_VAR = 8'b0100_0000,
      S_EMIT      = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   job_type    job_ff, job_in;
   logic [1:0] status_ff, status_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      status_in = status_ff;
      cmd             = '0;
      cmd.job         = job_ff;
      cmd.status      = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && last_row) state_in = S_DRAIN1;
         end
         S_DRAIN1: state_in = S_DRAIN2;
         S_DRAIN2: state_in = S_CHECK_W;
         S_CHECK_W: begin
            if (stat.weight_zero) begin
               status_in = STATUS_NO_WEIGHT;
               state_in  = S_EMIT;
            end else begin
               job_in   = JOB_W_SXX;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.mul_start = 1'b1;
            state_in      = S_RUN;
         end
         S_RUN: begin
            if (stat.mul_done) begin
               cmd.store = 1'b1;
               state_in  = S_ISSUE;
               unique case (job_ff)
                  JOB_W_SXX:   job_in = JOB_SX_SX;
                  JOB_SX_SX:   job_in = JOB_W_SYY;
                  JOB_W_SYY:   job_in = JOB_SY_SY;
                  JOB_SY_SY:   state_in = S_CHECK_VAR;
                  JOB_W_SXY:   job_in = JOB_SX_SY;
                  JOB_SX_SY:   job_in = JOB_VX_VY;
                  JOB_VX_VY:   job_in = JOB_NUM_NUM;
                  JOB_NUM_NUM: begin
                     cmd.search_init = 1'b1;
                     job_in          = JOB_ODD_SQ;
                  end
                  JOB_ODD_SQ:  job_in = JOB_C2_P;
                  JOB_C2_P: begin
                     if (stat.last_bit) begin
                        status_in = STATUS_OK;
                        state_in  = S_EMIT;
                     end else begin
                        job_in = JOB_ODD_SQ;
                     end
                  end
                  default:     state_in = S_EMIT;
               endcase
            end
         end
         S_CHECK_VAR: begin
            if (stat.var_bad) begin
               status_in = STATUS_ZERO_VAR;
               state_in  = S_EMIT;
            end else begin
               job_in   = JOB_W_SXY;
               state_in = S_ISSUE;
            end
         end
         S_EMIT: begin
            cmd.emit       = 1'b1;
            cmd.clear_sums = 1'b1;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         job_ff    <= JOB_W_SXX;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         job_ff    <= job_in;
         status_ff <= status_in;
      end
   end

endmodule

// File: sv/wpc_datapath.sv
// Row pipeline with the six running sums, a shift-add multiplier with signed
// accumulate, the finishing registers and the result register. Uses wpc_pkg.
module wpc_datapath
   import wpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [15:0] x_value,
   input  logic signed [15:0] y_value,
   input  logic [15:0]        weight,
   input  logic               x_present,
   input  logic               y_present,
   input  wpc_cmd_type        cmd,
   output wpc_stat_type       stat,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_correlation,
   output logic [1:0]         rsp_status
);

   // ---- row pipeline ----
   logic               s1_valid_ff, s1_valid_in;
   logic [15:0]        s1_w_ff;
   logic signed [15:0] s1_x_ff, s1_y_ff;
   logic signed [31:0] s1_wx_ff, s1_wy_ff;
   logic signed [32:0] wx_full, wy_full;

   logic               s2_valid_ff;
   logic [15:0]        s2_w_ff;
   logic signed [31:0] s2_wx_ff, s2_wy_ff;
   logic signed [47:0] s2_wxx_ff, s2_wyy_ff, s2_wxy_ff;
   logic signed [47:0] wxx_full, wyy_full, wxy_full;

   logic [WT_W-1:0]  w_sum_ff, w_sum_in;
   logic [SX_W-1:0]  sx_sum_ff, sx_sum_in, sy_sum_ff, sy_sum_in;
   logic [SXX_W-1:0] sxx_sum_ff, sxx_sum_in, syy_sum_ff, syy_sum_in;
   logic [SXY_W-1:0] sxy_sum_ff, sxy_sum_in;

   assign s1_valid_in = accept && x_present && y_present;
   assign wx_full  = $signed({1'b0, weight}) * x_value;
   assign wy_full  = $signed({1'b0, weight}) * y_value;
   assign wxx_full = s1_wx_ff * s1_x_ff;
   assign wyy_full = s1_wy_ff * s1_y_ff;
   assign wxy_full = s1_wx_ff * s1_y_ff;

   always_ff @(posedge clock) begin
      s1_w_ff   <= weight;
      s1_x_ff   <= x_value;
      s1_y_ff   <= y_value;
      s1_wx_ff  <= wx_full[31:0];
      s1_wy_ff  <= wy_full[31:0];
      s2_w_ff   <= s1_w_ff;
      s2_wx_ff  <= s1_wx_ff;
      s2_wy_ff  <= s1_wy_ff;
      s2_wxx_ff <= wxx_full;
      s2_wyy_ff <= wyy_full;
      s2_wxy_ff <= wxy_full;
   end

   always_comb begin
      w_sum_in   = w_sum_ff   + WT_W'(s2_w_ff);
      sx_sum_in  = sx_sum_ff  + {{(SX_W-32){s2_wx_ff[31]}}, s2_wx_ff};
      sy_sum_in  = sy_sum_ff  + {{(SX_W-32){s2_wy_ff[31]}}, s2_wy_ff};
      sxx_sum_in = sxx_sum_ff + {{(SXX_W-48){s2_wxx_ff[47]}}, s2_wxx_ff};
      syy_sum_in = syy_sum_ff + {{(SXX_W-48){s2_wyy_ff[47]}}, s2_wyy_ff};
      sxy_sum_in = sxy_sum_ff + {{(SXY_W-48){s2_wxy_ff[47]}}, s2_wxy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         w_sum_ff    <= '0;
         sx_sum_ff   <= '0;
         sy_sum_ff   <= '0;
         sxx_sum_ff  <= '0;
         syy_sum_ff  <= '0;
         sxy_sum_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            w_sum_ff   <= w_sum_in;
            sx_sum_ff  <= sx_sum_in;
            sy_sum_ff  <= sy_sum_in;
            sxx_sum_ff <= sxx_sum_in;
            syy_sum_ff <= syy_sum_in;
            sxy_sum_ff <= sxy_sum_in;
         end
      end
   end

   // ---- operand magnitudes ----
   logic             sx_neg, sy_neg, sxy_neg, num_neg;
   logic [SX_W-1:0]  sx_mag, sy_mag;
   logic [SXY_W-1:0] sxy_mag;
   logic [VAR_W-1:0] vx_ff, vy_ff, num_ff, num_mag;
   logic [ACC_W-1:0] p_ff;
   logic [LHS_W-1:0] lhs_ff;
   logic [C2_W-1:0]  c2_ff;
   logic [Q_W-1:0]   q_ff, cand;
   logic [BIT_W-1:0] bit_ff;
   logic [ODD_W-1:0] odd;

   assign sx_neg  = sx_sum_ff[SX_W-1];
   assign sy_neg  = sy_sum_ff[SX_W-1];
   assign sxy_neg = sxy_sum_ff[SXY_W-1];
   assign num_neg = num_ff[VAR_W-1];
   assign sx_mag  = sx_neg  ? (~sx_sum_ff + 1'b1)  : sx_sum_ff;
   assign sy_mag  = sy_neg  ? (~sy_sum_ff + 1'b1)  : sy_sum_ff;
   assign sxy_mag = sxy_neg ? (~sxy_sum_ff + 1'b1) : sxy_sum_ff;
   assign num_mag = num_neg ? (~num_ff + 1'b1)     : num_ff;
   assign cand    = q_ff | (Q_W'(1) << bit_ff);
   assign odd     = {cand, 1'b0} - ODD_W'(1);

   // ---- shift-add multiplier: acc += (+/-) mcand * mplier ----
   logic [ACC_W-1:0] mcand_ff, mcand_in, acc_ff, acc_in, addend;
   logic [VAR_W-1:0] mplier_ff, mplier_in;
   logic             neg_ff, neg_in;
   logic [ACC_W-1:0] op_mcand;
   logic [VAR_W-1:0] op_mplier;
   logic             op_neg, op_clear;

   always_comb begin
      op_mcand  = '0;
      op_mplier = '0;
      op_neg    = 1'b0;
      op_clear  = 1'b1;
      unique case (cmd.job)
         JOB_W_SXX: begin
            op_mcand  = ACC_W'(sxx_sum_ff);
            op_mplier = VAR_W'(w_sum_ff);
         end
         JOB_SX_SX: begin
            op_mcand  = ACC_W'(sx_mag);
            op_mplier = VAR_W'(sx_mag);
            op_neg    = 1'b1;
            op_clear  = 1'b0;
         end
         JOB_W_SYY: begin
            op_mcand  = ACC_W'(syy_sum_ff);
            op_mplier = VAR_W'(w_sum_ff);
         end
         JOB_SY_SY: begin
            op_mcand  = ACC_W'(sy_mag);
            op_mplier = VAR_W'(sy_mag);
            op_neg    = 1'b1;
            op_clear  = 1'b0;
         end
         JOB_W_SXY: begin
            op_mcand  = ACC_W'(sxy_mag);
            op_mplier = VAR_W'(w_sum_ff);
            op_neg    = sxy_neg;
         end
         JOB_SX_SY: begin
            // subtract Sx*Sy: negative step when the signs agree
            op_mcand  = ACC_W'(sx_mag);
            op_mplier = VAR_W'(sy_mag);
            op_neg    = ~(sx_neg ^ sy_neg);
            op_clear  = 1'b0;
         end
         JOB_VX_VY: begin
            op_mcand  = ACC_W'(vx_ff);
            op_mplier = vy_ff;
         end
         JOB_NUM_NUM: begin
            op_mcand  = ACC_W'(num_mag);
            op_mplier = num_mag;
         end
         JOB_ODD_SQ: begin
            op_mcand  = ACC_W'(odd);
            op_mplier = VAR_W'(odd);
         end
         JOB_C2_P: begin
            op_mcand  = p_ff;
            op_mplier = VAR_W'(c2_ff);
         end
         default: op_clear = 1'b1;
      endcase
   end

   assign addend = mcand_ff ^ {ACC_W{neg_ff}};

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      if (cmd.mul_start) begin
         mcand_in  = op_mcand;
         mplier_in = op_mplier;
         neg_in    = op_neg;
         acc_in    = op_clear ? '0 : acc_ff;
      end else if (mplier_ff != '0) begin
         if (mplier_ff[0]) acc_in = acc_ff + addend + ACC_W'(neg_ff);
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mplier_ff <= '0;
      end else begin
         mplier_ff <= mplier_in;
      end
      mcand_ff <= mcand_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
   end

   // ---- store results of finished jobs, run the bit search ----
   logic rhs_fits;
   assign rhs_fits = (acc_ff <= {lhs_ff, {(ACC_W-LHS_W){1'b0}}}) && (cand <= Q_LIMIT);

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.job)
            JOB_SX_SX:   vx_ff  <= acc_ff[VAR_W-1:0];
            JOB_SY_SY:   vy_ff  <= acc_ff[VAR_W-1:0];
            JOB_SX_SY:   num_ff <= acc_ff[VAR_W-1:0];
            JOB_VX_VY:   p_ff   <= acc_ff;
            JOB_NUM_NUM: lhs_ff <= acc_ff[LHS_W-1:0];
            JOB_ODD_SQ:  c2_ff  <= acc_ff[C2_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff   <= '0;
         bit_ff <= '0;
      end else if (cmd.search_init) begin
         q_ff   <= '0;
         bit_ff <= BIT_W'(Q_W - 1);
      end else if (cmd.store && cmd.job == JOB_C2_P) begin
         if (rhs_fits) q_ff <= cand;
         bit_ff <= bit_ff - 1'b1;
      end
   end

   assign stat.mul_done    = (mplier_ff == '0);
   assign stat.weight_zero = (w_sum_ff == '0);
   assign stat.var_bad     = vx_ff[VAR_W-1] || (vx_ff == '0) ||
                             vy_ff[VAR_W-1] || (vy_ff == '0);
   assign stat.last_bit    = (bit_ff == '0);

   // ---- result register ----
   logic        strobe_ff;
   logic [15:0] corr_ff, corr_in;
   logic [1:0]  status_ff;

   always_comb begin
      if (cmd.status != STATUS_OK) corr_in = '0;
      else if (num_neg)            corr_in = ~q_ff + 1'b1;
      else if (q_ff[Q_W-1])        corr_in = CORR_MAX;
      else                         corr_in = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         corr_ff   <= corr_in;
         status_ff <= cmd.status;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_correlation = corr_ff;
   assign rsp_status      = status_ff;

endmodule

// File: sv/weighted_pearson_correlation_core.sv
// Weighted Pearson correlation core: top level joining wpc_controller and
// wpc_datapath. Depends on wpc_pkg.
//
// Usage: drive one row per cycle on req_* with start high; a row transfers
// when start is high and busy is low. Rows with either present bit clear are
// skipped. While busy is low a row transfers every cycle.
// A row with req_last_row set closes the column pair: busy rises on the next
// cycle and stays high while the sums are reduced by a one-bit-per-cycle
// shift-add multiplier. Each multiply runs until its multiplier operand has
// shifted down to zero; the full reduction takes six product terms, two large
// products and a 16-step bit search of two multiplies each. A pair with zero
// variance stops after the first four products, and a pair with zero total
// weight finishes without any multiply.
// The result shows on rsp_correlation / rsp_status for exactly one cycle with
// rsp_strobe high, in the first cycle after busy falls; the receiver cannot
// stall it. The sums clear after each result.
// Reset (synchronous, active high) clears the sums and returns to idle.
module weighted_pearson_correlation_core
   import wpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_y_value,
   input  logic [15:0]        req_weight,
   input  logic               req_x_present,
   input  logic               req_y_present,
   input  logic               req_last_row,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_correlation,
   output logic [1:0]         rsp_status
);

   wpc_cmd_type  cmd;
   wpc_stat_type stat;
   logic         accept;

   assign accept = start && !busy;

   wpc_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .last_row (req_last_row),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   wpc_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .x_value         (req_x_value),
      .y_value         (req_y_value),
      .weight          (req_weight),
      .x_present       (req_x_present),
      .y_present       (req_y_present),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_correlation (rsp_correlation),
      .rsp_status      (rsp_status)
   );

   a_last_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_row) |=> busy)
      else $error("busy did not rise after last row");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NO_WEIGHT ||
                      rsp_status == STATUS_ZERO_VAR))
      else $error("bad status code");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_OK) |-> (rsp_correlation == 16'sd0))
      else $error("nonzero correlation with fault status");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held two cycles");

endmodule

// File: test/tb_weighted_pearson_correlation_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for weighted_pearson_correlation_core: directed rows from a table,
// then random column pairs; typed rows carry their expected result, other pairs are scored
// against an exact big-integer predictor of the sums. Depends on wpc_pkg and the core RTL.
module tb_weighted_pearson_correlation_core;
   import wpc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        w;
      logic               xp;
      logic               yp;
      logic               last;
      logic               typed;
      logic signed [15:0] corr;
      logic [1:0]         status;
   } row_type;

   typedef struct {
      logic signed [15:0] corr;
      logic [1:0]         status;
   } pair_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_x_value = '0;
   logic signed [15:0] req_y_value = '0;
   logic [15:0]        req_weight = '0;
   logic               req_x_present = 1'b0;
   logic               req_y_present = 1'b0;
   logic               req_last_row = 1'b0;
   logic               rsp_strobe;
   logic signed [15:0] rsp_correlation;
   logic [1:0]         rsp_status;

   // predictor copy of the running sums
   logic [WT_W-1:0]  pr_weight_total;
   logic [SX_W-1:0]  pr_x_sum, pr_y_sum;
   logic [SXX_W-1:0] pr_xx_sum, pr_yy_sum;
   logic [SXY_W-1:0] pr_xy_sum;

   pair_result_type pending_results[$];
   row_type         directed_rows[$];
   int              error_count = 0;
   int              idle_cycles = 0;
   logic            no_gaps = 1'b0;
   logic            held = 1'b0;

   weighted_pearson_correlation_core u_dut (.*);

   always #4 clock = ~clock;

   function automatic void clear_pair_sums();
      pr_weight_total = '0;
      pr_x_sum = '0;
      pr_y_sum = '0;
      pr_xx_sum = '0;
      pr_yy_sum = '0;
      pr_xy_sum = '0;
   endfunction

   function automatic pair_result_type reduce_pair();
      logic [255:0] w, sx, sy, sxx, syy, sxy, vx, vy, num, p, lhs, t;
      int unsigned lo, hi, mid;
      logic neg;
      pair_result_type r;
      r.corr = '0;
      w = {227'b0, pr_weight_total};
      sx = {{210{pr_x_sum[SX_W-1]}}, pr_x_sum};
      sy = {{210{pr_y_sum[SX_W-1]}}, pr_y_sum};
      sxx = {197'b0, pr_xx_sum};
      syy = {197'b0, pr_yy_sum};
      sxy = {{196{pr_xy_sum[SXY_W-1]}}, pr_xy_sum};
      if (w == 0) begin
         r.status = STATUS_NO_WEIGHT;
         return r;
      end
      vx = w * sxx - sx * sx;
      vy = w * syy - sy * sy;
      if (vx[255] || vx == 0 || vy[255] || vy == 0) begin
         r.status = STATUS_ZERO_VAR;
         return r;
      end
      num = w * sxy - sx * sy;
      neg = num[255];
      if (neg) num = -num;
      p = vx * vy;
      lhs = (num * num) << 32;
      // largest q with (2q-1)^2 * P <= 2^32 * num^2
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 256'(2 * mid - 1);
         if (t * t * p <= lhs) lo = mid;
         else hi = mid - 1;
      end
      if (neg) r.corr = -16'(lo);
      else r.corr = (lo > 32767) ? CORR_MAX : 16'(lo);
      r.status = STATUS_OK;
      return r;
   endfunction

   function automatic void take_row(row_type rw);
      longint x, y, w;
      x = rw.x;
      y = rw.y;
      w = rw.w;
      if (rw.xp && rw.yp) begin
         pr_weight_total += WT_W'(w);
         pr_x_sum += SX_W'(w * x);
         pr_y_sum += SX_W'(w * y);
         pr_xx_sum += SXX_W'(w * x * x);
         pr_yy_sum += SXX_W'(w * y * y);
         pr_xy_sum += SXY_W'(w * x * y);
      end
      if (rw.last) begin
         if (rw.typed) pending_results.push_back('{rw.corr, rw.status});
         else pending_results.push_back(reduce_pair());
         clear_pair_sums();
      end
   endfunction

   // start stays high into the next row unless an idle gap drops it
   task automatic send_row(row_type rw);
      if (!no_gaps)
         while ($urandom_range(99) < 28) begin
            start <= 1'b0;
            @(negedge clock);
         end
      start <= 1'b1;
      req_x_value <= rw.x;
      req_y_value <= rw.y;
      req_weight <= rw.w;
      req_x_present <= rw.xp;
      req_y_present <= rw.yp;
      req_last_row <= rw.last;
      do @(posedge clock); while (busy !== 1'b0);
      take_row(rw);
      @(negedge clock);
   endtask

   function automatic row_type plain_row(logic signed [15:0] x, logic signed [15:0] y,
                                         logic [15:0] w, logic xp, logic yp, logic last);
      row_type rw;
      rw = '{x, y, w, xp, yp, last, 1'b0, 16'sd0, STATUS_OK};
      return rw;
   endfunction

   function automatic row_type typed_row(logic signed [15:0] x, logic signed [15:0] y,
                                         logic [15:0] w, logic xp, logic yp,
                                         logic signed [15:0] corr, logic [1:0] status);
      row_type rw;
      rw = '{x, y, w, xp, yp, 1'b1, 1'b1, corr, status};
      return rw;
   endfunction

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($signed($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic row_type random_row(logic last, logic signed [15:0] slope_hint);
      row_type rw;
      logic signed [15:0] x;
      x = random_sample();
      rw = plain_row(x, random_sample(), 16'($urandom), 1'b1, 1'b1, last);
      case ($urandom_range(9))
         0: rw.w = 16'hFFFF;
         1: rw.w = 16'h0000;
         2: rw.w = 16'($urandom_range(15));
         default: ;
      endcase
      // follow x for part of the pairs so that strong correlations appear
      if (slope_hint != 0) rw.y = 16'(x * slope_hint + $signed($urandom_range(64)) - 32);
      if ($urandom_range(99) < 6) rw.xp = 1'b0;
      if ($urandom_range(99) < 6) rw.yp = 1'b0;
      return rw;
   endfunction

   task automatic send_pair(int rows);
      logic signed [15:0] slope;
      case ($urandom_range(3))
         0: slope = 16'sd1;
         1: slope = -16'sd1;
         default: slope = 16'sd0;
      endcase
      for (int i = 0; i < rows; i++) send_row(random_row(i == rows - 1, slope));
   endtask

   // result checking
   always @(posedge clock) begin
      pair_result_type exp_r;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result corr=%0d status=%0d", $time,
                     rsp_correlation, rsp_status);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_correlation !== exp_r.corr) begin
               $display("%0t: correlation expected %0d actual %0d", $time,
                        exp_r.corr, rsp_correlation);
               error_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_r.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer in either direction
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int rows;
      clear_pair_sums();
      directed_rows.push_back(typed_row(16'sd100, 16'sd100, 16'h0000, 1'b1, 1'b1, 16'sd0,
                                        STATUS_NO_WEIGHT));
      directed_rows.push_back(typed_row(16'sd5, 16'sd7, 16'hFFFF, 1'b0, 1'b1, 16'sd0,
                                        STATUS_NO_WEIGHT));
      directed_rows.push_back(typed_row(16'sd5, 16'sd7, 16'hFFFF, 1'b1, 1'b0, 16'sd0,
                                        STATUS_NO_WEIGHT));
      directed_rows.push_back(typed_row(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1, 1'b1, 16'sd0,
                                        STATUS_ZERO_VAR));
      directed_rows.push_back(plain_row(16'sh8000, 16'sh8000, 16'hFFFF, 1'b1, 1'b1, 1'b0));
      directed_rows.push_back(typed_row(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b1,
                                        CORR_MAX, STATUS_OK));
      directed_rows.push_back(plain_row(16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b1, 1'b0));
      directed_rows.push_back(typed_row(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1, 1'b1,
                                        -16'sd32768, STATUS_OK));
      // constant y over varying x
      directed_rows.push_back(plain_row(16'sd1, 16'sd9, 16'd3, 1'b1, 1'b1, 1'b0));
      directed_rows.push_back(typed_row(16'sd4, 16'sd9, 16'd5, 1'b1, 1'b1, 16'sd0,
                                        STATUS_ZERO_VAR));
      // a skipped row inside a live pair
      directed_rows.push_back(plain_row(16'sd256, 16'sd512, 16'd1, 1'b1, 1'b1, 1'b0));
      directed_rows.push_back(plain_row(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0, 1'b0, 1'b0));
      directed_rows.push_back(plain_row(-16'sd256, 16'sd100, 16'd2, 1'b1, 1'b1, 1'b0));
      directed_rows.push_back(plain_row(16'sd30, -16'sd900, 16'h8000, 1'b1, 1'b1, 1'b1));
      directed_rows.push_back(plain_row(16'sd1, 16'sd2, 16'd1, 1'b1, 1'b1, 1'b0));
      directed_rows.push_back(plain_row(16'sd2, 16'sd3, 16'd1, 1'b1, 1'b1, 1'b0));
      directed_rows.push_back(plain_row(16'sd3, 16'sd1, 16'd1, 1'b1, 1'b1, 1'b1));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);

      rows = 0;
      while (rows < 600) begin
         no_gaps = (rows >= 250 && rows < 330);
         if (rows >= 400 && !held) begin
            // hold the sender until every pending result is out
            held = 1'b1;
            start <= 1'b0;
            wait (pending_results.size() == 0);
            @(negedge clock);
         end
         if ($urandom_range(9) == 0) begin
            send_row(random_row(1'b0, 16'sd0));
            rows++;
         end else begin
            int n;
            n = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
            send_pair(n);
            rows += n;
         end
      end
      no_gaps = 1'b0;
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
sv/wpc_pkg.sv
sv/wpc_controller.sv
sv/wpc_datapath.sv
sv/weighted_pearson_correlation_core.sv
test/tb_weighted_pearson_correlation_core.sv
